/* design/adll_pkg.sv */
// Types, codes and microcode ROM for the array doubly linked list unit.
`timescale 1ns / 1ps

package adll_pkg;

   typedef logic [4:0] pc_type;

   typedef enum logic [2:0] {
      OP_CLEAR      = 3'd0,
      OP_SET_ENDS   = 3'd1,
      OP_LOAD       = 3'd2,
      OP_DELETE     = 3'd3,
      OP_INS_AFTER  = 3'd4,
      OP_INS_BEFORE = 3'd5,
      OP_READ       = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE = 2'd0,
      COND_BAD  = 2'd1,
      COND_FULL = 2'd2
   } cond_type;

   typedef enum logic [2:0] {
      SRC_ZERO    = 3'd0,
      SRC_A       = 3'd1,
      SRC_B       = 3'd2,
      SRC_F       = 3'd3,
      SRC_NB      = 3'd4,
      SRC_RD_NEXT = 3'd5,
      SRC_RD_PREV = 3'd6
   } src_type;

   typedef enum logic [1:0] {
      NB_HOLD = 2'd0,
      NB_NEXT = 2'd1,
      NB_PREV = 2'd2
   } nb_type;

   typedef enum logic [2:0] {
      RSP_ZERO  = 3'd0,
      RSP_FULL  = 3'd1,
      RSP_FRESH = 3'd2,
      RSP_VAL   = 3'd3,
      RSP_READ  = 3'd4
   } rsp_type;

   typedef struct packed {
      cond_type cond;
      pc_type   target;
      logic     last;
      src_type  next_addr;
      src_type  next_data;
      logic     next_we;
      src_type  prev_addr;
      src_type  prev_data;
      logic     prev_we;
      src_type  val_addr;
      logic     val_we;
      nb_type   nb_op;
      logic     nfs_clear;
      logic     nfs_inc;
      rsp_type  rsp;
   } uword_type;

   localparam pc_type ST_NOP        = 5'd0;
   localparam pc_type ST_CLEAR      = 5'd1;
   localparam pc_type ST_SET_ENDS   = 5'd2;
   localparam pc_type ST_LOAD       = 5'd4;
   localparam pc_type ST_FULL       = 5'd7;
   localparam pc_type ST_DELETE     = 5'd8;
   localparam pc_type ST_INS_AFTER  = 5'd10;
   localparam pc_type ST_INS_BEFORE = 5'd14;
   localparam pc_type ST_READ       = 5'd18;

   function automatic pc_type entry_step(input logic [2:0] op);
      pc_type s;
      case (op)
         OP_CLEAR:      s = ST_CLEAR;
         OP_SET_ENDS:   s = ST_SET_ENDS;
         OP_LOAD:       s = ST_LOAD;
         OP_DELETE:     s = ST_DELETE;
         OP_INS_AFTER:  s = ST_INS_AFTER;
         OP_INS_BEFORE: s = ST_INS_BEFORE;
         OP_READ:       s = ST_READ;
         default:       s = ST_NOP;
      endcase
      return s;
   endfunction

   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      w = '0;
      case (pc)
         ST_NOP: begin
            w.last = 1'b1;
         end
         ST_CLEAR: begin
            w.next_addr = SRC_ZERO;
            w.next_data = SRC_ZERO;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_ZERO;
            w.prev_data = SRC_ZERO;
            w.prev_we   = 1'b1;
            w.nfs_clear = 1'b1;
            w.last      = 1'b1;
         end
         ST_SET_ENDS: begin
            w.cond   = COND_BAD;
            w.target = ST_NOP;
         end
         ST_SET_ENDS + 5'd1: begin
            w.next_addr = SRC_ZERO;
            w.next_data = SRC_A;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_ZERO;
            w.prev_data = SRC_B;
            w.prev_we   = 1'b1;
            w.last      = 1'b1;
         end
         ST_LOAD: begin
            w.cond   = COND_BAD;
            w.target = ST_NOP;
         end
         ST_LOAD + 5'd1: begin
            w.cond   = COND_FULL;
            w.target = ST_FULL;
         end
         ST_LOAD + 5'd2: begin
            w.val_addr  = SRC_F;
            w.val_we    = 1'b1;
            w.next_addr = SRC_F;
            w.next_data = SRC_A;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_F;
            w.prev_data = SRC_B;
            w.prev_we   = 1'b1;
            w.nfs_inc   = 1'b1;
            w.rsp       = RSP_FRESH;
            w.last      = 1'b1;
         end
         ST_FULL: begin
            w.rsp  = RSP_FULL;
            w.last = 1'b1;
         end
         ST_DELETE: begin
            w.cond      = COND_BAD;
            w.target    = ST_NOP;
            w.next_addr = SRC_A;
            w.prev_addr = SRC_A;
            w.val_addr  = SRC_A;
         end
         ST_DELETE + 5'd1: begin
            w.next_addr = SRC_RD_PREV;
            w.next_data = SRC_RD_NEXT;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_RD_NEXT;
            w.prev_data = SRC_RD_PREV;
            w.prev_we   = 1'b1;
            w.rsp       = RSP_VAL;
            w.last      = 1'b1;
         end
         ST_INS_AFTER: begin
            w.cond      = COND_BAD;
            w.target    = ST_NOP;
            w.next_addr = SRC_A;
         end
         ST_INS_AFTER + 5'd1: begin
            w.cond   = COND_FULL;
            w.target = ST_FULL;
            w.nb_op  = NB_NEXT;
         end
         ST_INS_AFTER + 5'd2: begin
            w.val_addr  = SRC_F;
            w.val_we    = 1'b1;
            w.next_addr = SRC_F;
            w.next_data = SRC_NB;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_F;
            w.prev_data = SRC_A;
            w.prev_we   = 1'b1;
         end
         ST_INS_AFTER + 5'd3: begin
            w.next_addr = SRC_A;
            w.next_data = SRC_F;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_NB;
            w.prev_data = SRC_F;
            w.prev_we   = 1'b1;
            w.nfs_inc   = 1'b1;
            w.rsp       = RSP_FRESH;
            w.last      = 1'b1;
         end
         ST_INS_BEFORE: begin
            w.cond      = COND_BAD;
            w.target    = ST_NOP;
            w.prev_addr = SRC_A;
         end
         ST_INS_BEFORE + 5'd1: begin
            w.cond   = COND_FULL;
            w.target = ST_FULL;
            w.nb_op  = NB_PREV;
         end
         ST_INS_BEFORE + 5'd2: begin
            w.val_addr  = SRC_F;
            w.val_we    = 1'b1;
            w.prev_addr = SRC_F;
            w.prev_data = SRC_NB;
            w.prev_we   = 1'b1;
            w.next_addr = SRC_F;
            w.next_data = SRC_A;
            w.next_we   = 1'b1;
         end
         ST_INS_BEFORE + 5'd3: begin
            w.next_addr = SRC_NB;
            w.next_data = SRC_F;
            w.next_we   = 1'b1;
            w.prev_addr = SRC_A;
            w.prev_data = SRC_F;
            w.prev_we   = 1'b1;
            w.nfs_inc   = 1'b1;
            w.rsp       = RSP_FRESH;
            w.last      = 1'b1;
         end
         ST_READ: begin
            w.cond      = COND_BAD;
            w.target    = ST_NOP;
            w.val_addr  = SRC_A;
            w.next_addr = SRC_A;
         end
         ST_READ + 5'd1: begin
            w.rsp  = RSP_READ;
            w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

/* design/adll_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module adll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/array_doubly_linked_list_unit.sv */
// Top level: circular doubly linked list in a node store, run by a microcoded sequencer.
//
//   channel   ports                                          handshake
//   request   req_op req_node_index req_other_index          start, busy
//             req_payload
//   response  rsp_value rsp_successor rsp_full_res           rsp_strobe (one cycle)
//
// An item runs 1 to 4 microcode steps, one step per cycle: clear 1, set ends 2, read 2,
// delete 2, load 3, insert 4; an out-of-range index ends a load or an insert early,
// and a full store ends an insert early.
// The steps are set by the single-port link memories: insert reads one link, then
// writes each link memory twice. The response strobes in the cycle after the last
// step, and start is taken again in that same cycle.
// After reset a clearing pass writes zero links to all NODE_SLOTS slots, one per
// cycle, with busy high. The receiver cannot stall; results are never held.
`timescale 1ns / 1ps

module array_doubly_linked_list_unit #(
   parameter int NODE_SLOTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic signed [10:0] req_node_index,
   input  logic signed [10:0] req_other_index,
   input  logic signed [31:0] req_payload,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_value,
   output logic signed [10:0] rsp_successor,
   output logic               rsp_full_res
);

   import adll_pkg::*;

   localparam int SLOT_W = $clog2(NODE_SLOTS);
   localparam int NFS_W  = $clog2(NODE_SLOTS + 1);

   function automatic logic [SLOT_W-1:0] pick(
      input src_type           s,
      input logic [SLOT_W-1:0] a,
      input logic [SLOT_W-1:0] b,
      input logic [SLOT_W-1:0] f,
      input logic [SLOT_W-1:0] nb,
      input logic [SLOT_W-1:0] rn,
      input logic [SLOT_W-1:0] rp
   );
      logic [SLOT_W-1:0] r;
      case (s)
         SRC_A:       r = a;
         SRC_B:       r = b;
         SRC_F:       r = f;
         SRC_NB:      r = nb;
         SRC_RD_NEXT: r = rn;
         SRC_RD_PREV: r = rp;
         default:     r = '0;
      endcase
      return r;
   endfunction

   logic               run_ff,  run_in;
   logic               wipe_ff, wipe_in;
   logic [SLOT_W-1:0]  wcnt_ff, wcnt_in;
   pc_type             pc_ff,   pc_in;
   logic               bad_ff,  bad_in;
   logic [SLOT_W-1:0]  a_ff,    a_in;
   logic [SLOT_W-1:0]  b_ff,    b_in;
   logic [31:0]        pay_ff,  pay_in;
   logic [SLOT_W-1:0]  nb_ff,   nb_in;
   logic [NFS_W-1:0]   nfs_ff,  nfs_in;
   logic               strb_ff, strb_in;
   logic [31:0]        val_ff,  val_in;
   logic [10:0]        succ_ff, succ_in;
   logic               full_ff, full_in;

   uword_type          uw;
   logic               accept;
   logic               full;
   logic               hit;
   logic signed [11:0] a_sum;
   logic signed [11:0] b_sum;
   logic               a_ok;
   logic               b_ok;
   logic               need_b;
   logic [SLOT_W-1:0]  fresh;

   logic               next_we,   prev_we,   val_we;
   logic [SLOT_W-1:0]  next_addr, prev_addr, val_addr;
   logic [SLOT_W-1:0]  next_wd,   prev_wd;
   logic [SLOT_W-1:0]  next_rd,   prev_rd;
   logic [31:0]        val_rd;

   adll_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_SLOTS)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .addr  (next_addr),
      .wdata (next_wd),
      .rdata (next_rd)
   );

   adll_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
      .clock (clock),
      .we    (prev_we),
      .addr  (prev_addr),
      .wdata (prev_wd),
      .rdata (prev_rd)
   );

   adll_ram #(.WIDTH(32), .DEPTH(NODE_SLOTS)) u_val_ram (
      .clock (clock),
      .we    (val_we),
      .addr  (val_addr),
      .wdata (pay_ff),
      .rdata (val_rd)
   );

   assign busy   = run_ff | wipe_ff;
   assign accept = start & ~busy;
   assign uw     = ucode(pc_ff);
   assign full   = (nfs_ff == NFS_W'(NODE_SLOTS));
   assign fresh  = SLOT_W'(nfs_ff);

   assign a_sum  = {req_node_index[10], req_node_index} + 12'sd1;
   assign b_sum  = {req_other_index[10], req_other_index} + 12'sd1;
   assign a_ok   = ~a_sum[11] && (32'(a_sum[10:0]) < NODE_SLOTS);
   assign b_ok   = ~b_sum[11] && (32'(b_sum[10:0]) < NODE_SLOTS);
   assign need_b = (req_op == OP_SET_ENDS) || (req_op == OP_LOAD);

   always_comb begin
      case (uw.cond)
         COND_BAD:  hit = bad_ff;
         COND_FULL: hit = full;
         default:   hit = 1'b0;
      endcase
   end

   always_comb begin
      next_we   = wipe_ff | (run_ff & uw.next_we);
      prev_we   = wipe_ff | (run_ff & uw.prev_we);
      val_we    = run_ff & uw.val_we;
      next_addr = wipe_ff ? wcnt_ff
                          : pick(uw.next_addr, a_ff, b_ff, fresh, nb_ff, next_rd, prev_rd);
      prev_addr = wipe_ff ? wcnt_ff
                          : pick(uw.prev_addr, a_ff, b_ff, fresh, nb_ff, next_rd, prev_rd);
      next_wd   = wipe_ff ? '0
                          : pick(uw.next_data, a_ff, b_ff, fresh, nb_ff, next_rd, prev_rd);
      prev_wd   = wipe_ff ? '0
                          : pick(uw.prev_data, a_ff, b_ff, fresh, nb_ff, next_rd, prev_rd);
      val_addr  = pick(uw.val_addr, a_ff, b_ff, fresh, nb_ff, next_rd, prev_rd);
   end

   always_comb begin
      run_in  = run_ff;
      wipe_in = wipe_ff;
      wcnt_in = wcnt_ff;
      pc_in   = pc_ff;
      bad_in  = bad_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pay_in  = pay_ff;
      nb_in   = nb_ff;
      nfs_in  = nfs_ff;
      strb_in = 1'b0;
      val_in  = val_ff;
      succ_in = succ_ff;
      full_in = full_ff;

      if (wipe_ff) begin
         wcnt_in = wcnt_ff + 1'b1;
         if (wcnt_ff == SLOT_W'(NODE_SLOTS - 1)) begin
            wipe_in = 1'b0;
         end
      end

      if (accept) begin
         run_in = 1'b1;
         pc_in  = entry_step(req_op);
         bad_in = ~a_ok | (need_b & ~b_ok);
         a_in   = SLOT_W'(a_sum[10:0]);
         b_in   = SLOT_W'(b_sum[10:0]);
         pay_in = req_payload;
      end else if (run_ff) begin
         case (uw.nb_op)
            NB_NEXT: nb_in = next_rd;
            NB_PREV: nb_in = prev_rd;
            default: nb_in = nb_ff;
         endcase
         if (uw.nfs_clear) begin
            nfs_in = NFS_W'(1);
         end else if (uw.nfs_inc) begin
            nfs_in = nfs_ff + 1'b1;
         end
         if (uw.last) begin
            run_in  = 1'b0;
            strb_in = 1'b1;
            val_in  = '0;
            succ_in = '0;
            full_in = 1'b0;
            case (uw.rsp)
               RSP_FULL:  full_in = 1'b1;
               RSP_FRESH: val_in  = 32'(nfs_ff) - 32'd1;
               RSP_VAL:   val_in  = val_rd;
               RSP_READ: begin
                  val_in  = val_rd;
                  succ_in = 11'(32'(next_rd) - 32'd1);
               end
               default:   val_in  = '0;
            endcase
         end else if (hit) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         wipe_ff <= 1'b1;
         wcnt_ff <= '0;
         pc_ff   <= ST_NOP;
         nfs_ff  <= NFS_W'(1);
         strb_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         wipe_ff <= wipe_in;
         wcnt_ff <= wcnt_in;
         pc_ff   <= pc_in;
         nfs_ff  <= nfs_in;
         strb_ff <= strb_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff  <= bad_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      pay_ff  <= pay_in;
      nb_ff   <= nb_in;
      val_ff  <= val_in;
      succ_ff <= succ_in;
      full_ff <= full_in;
   end

   assign rsp_strobe    = strb_ff;
   assign rsp_value     = val_ff;
   assign rsp_successor = succ_ff;
   assign rsp_full_res  = full_ff;

endmodule
